// ===== hdl/rffc_pkg.sv =====
package rffc_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgStationAddress = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgExpectedFrameType = 1'b1;
  localparam int unsigned CfgDataW = 16;

  // register reset values
  localparam logic [15:0] StationAddressReset = 16'h0000;
  localparam logic [7:0] ExpectedFrameTypeReset = 8'h02;

  // frame layout
  localparam logic [7:0] MinFrameLength = 8'd7;
  localparam logic [7:0] PosAddrHigh = 8'd0;
  localparam logic [7:0] PosAddrLow = 8'd1;
  localparam logic [7:0] PosFrameType = 8'd2;
  localparam logic [7:0] PosLength = 8'd4;
  localparam logic [7:0] LastHeaderPos = 8'd4;
  localparam logic [8:0] TrailerBytes = 9'd2;

  // stream widths
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 24;

  // header and checksum flags kept through a frame
  typedef struct packed {
    logic sum_a_match;
    logic type_match;
    logic address_match;
  } hdr_flags_t;

  // one verdict
  typedef struct packed {
    logic [7:0] sum_b_out;
    logic [7:0] sum_a_out;
    logic       length_error;
    logic       checksum_match;
    logic       type_match;
    logic       address_match;
    logic       frame_ok;
  } verdict_t;

endpackage

// ===== hdl/radio_frame_fletcher_checker_core.sv =====
// channel   | direction | tdata (low bit up)                         | tuser
// s_axis    | in        | rx_byte[7:0]                               | frame_start
// m_axis    | out       | frame_ok, address_match, type_match,       | -
//           |           | checksum_match, length_error, sum_a_out,   |
//           |           | sum_b_out, three zero bits                 |
// cfg       | in        | cfg_we_i, cfg_addr_i, cfg_wdata_i[15:0]     | -
//
// one byte per cycle unless stalled: each byte takes a single pass through the
// frame state and the two 8-bit Fletcher adders; a verdict is registered in the
// result register on the closing byte (or the length byte if short).
// reset clears frame state and the valid flag and loads configuration defaults.
// a pending verdict stalls input only while m_axis_tready is low.
module radio_frame_fletcher_checker_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input bytes
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rffc_pkg::InDataW-1:0]        s_axis_tdata,  // rx_byte[7:0]
  input  logic                                s_axis_tuser,  // frame_start
  // verdicts
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // frame_ok, address_match, type_match, checksum_match, length_error,
  // sum_a_out[7:0], sum_b_out[7:0], zero padding
  output logic [rffc_pkg::OutDataW-1:0]       m_axis_tdata,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [rffc_pkg::CfgIdxW-1:0]        cfg_addr_i,
  input  logic [rffc_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  // configuration registers
  logic [15:0] station_address_q;
  logic [7:0]  expected_frame_type_q;

  // frame state
  logic [7:0]           byte_pos_q, byte_pos_d;
  logic [7:0]           frame_len_q, frame_len_d;
  logic [7:0]           sum_a_q, sum_a_d;
  logic [7:0]           sum_b_q, sum_b_d;
  logic [7:0]           addr_hi_q, addr_hi_d;
  rffc_pkg::hdr_flags_t flags_q, flags_d;
  logic                 active_q, active_d;

  // result register
  logic               out_valid_q, out_valid_d;
  rffc_pkg::verdict_t verdict_q, verdict_d;

  logic               in_accept;
  logic               emit;
  rffc_pkg::verdict_t emit_verdict;

  // working copies after a start marker
  logic [7:0]           cur_pos;
  logic [7:0]           cur_len;
  logic [7:0]           cur_a;
  logic [7:0]           cur_b;
  logic [7:0]           cur_hi;
  rffc_pkg::hdr_flags_t cur_flags;
  logic                 cur_active;
  logic [7:0]           rx_byte;
  logic [7:0]           add_a;
  logic [7:0]           add_b;
  logic [8:0]           pos_plus_trailer;
  logic                 ck_match;

  assign rx_byte = s_axis_tdata;

  // accept whenever the result register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_address_q <= rffc_pkg::StationAddressReset;
      expected_frame_type_q <= rffc_pkg::ExpectedFrameTypeReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rffc_pkg::CfgStationAddress: station_address_q <= cfg_wdata_i;
        rffc_pkg::CfgExpectedFrameType: expected_frame_type_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // state seen by this byte, cleared by a start marker
  always_comb begin
    if (s_axis_tuser) begin
      cur_pos = '0;
      cur_len = '0;
      cur_a = '0;
      cur_b = '0;
      cur_hi = '0;
      cur_flags = '0;
      cur_active = 1'b1;
    end else begin
      cur_pos = byte_pos_q;
      cur_len = frame_len_q;
      cur_a = sum_a_q;
      cur_b = sum_b_q;
      cur_hi = addr_hi_q;
      cur_flags = flags_q;
      cur_active = active_q;
    end
  end

  // fletcher adders
  assign add_a = cur_a + rx_byte;
  assign add_b = cur_b + add_a;
  assign pos_plus_trailer = {1'b0, cur_pos} + rffc_pkg::TrailerBytes;
  assign ck_match = cur_flags.sum_a_match && (rx_byte == cur_b);

  // per-byte frame step
  always_comb begin
    byte_pos_d = byte_pos_q;
    frame_len_d = frame_len_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    addr_hi_d = addr_hi_q;
    flags_d = flags_q;
    active_d = active_q;
    emit = 1'b0;
    emit_verdict = '0;

    if (in_accept) begin
      byte_pos_d = cur_pos;
      frame_len_d = cur_len;
      sum_a_d = cur_a;
      sum_b_d = cur_b;
      addr_hi_d = cur_hi;
      flags_d = cur_flags;
      active_d = cur_active;

      if (cur_active) begin
        byte_pos_d = cur_pos + 8'd1;
        if (cur_pos <= rffc_pkg::LastHeaderPos) begin
          // header bytes, covered by the sums unless the length is short
          sum_a_d = add_a;
          sum_b_d = add_b;
          case (cur_pos)
            rffc_pkg::PosAddrHigh: addr_hi_d = rx_byte;
            rffc_pkg::PosAddrLow: begin
              if ({cur_hi, rx_byte} == station_address_q) begin
                flags_d.address_match = 1'b1;
              end
            end
            rffc_pkg::PosFrameType: begin
              if (rx_byte == expected_frame_type_q) begin
                flags_d.type_match = 1'b1;
              end
            end
            rffc_pkg::PosLength: begin
              frame_len_d = rx_byte;
              if (rx_byte < rffc_pkg::MinFrameLength) begin
                // short frame: reject at once, sums untouched
                sum_a_d = cur_a;
                sum_b_d = cur_b;
                active_d = 1'b0;
                emit = 1'b1;
                emit_verdict.length_error = 1'b1;
                emit_verdict.address_match = cur_flags.address_match;
                emit_verdict.type_match = cur_flags.type_match;
              end
            end
            default: ;
          endcase
        end else if (pos_plus_trailer < {1'b0, cur_len}) begin
          // payload byte
          sum_a_d = add_a;
          sum_b_d = add_b;
        end else if (pos_plus_trailer == {1'b0, cur_len}) begin
          // first checksum byte carries sum a
          if (rx_byte == cur_a) begin
            flags_d.sum_a_match = 1'b1;
          end
        end else begin
          // last byte carries sum b
          active_d = 1'b0;
          emit = 1'b1;
          emit_verdict.checksum_match = ck_match;
          emit_verdict.address_match = cur_flags.address_match;
          emit_verdict.type_match = cur_flags.type_match;
          emit_verdict.frame_ok = ck_match && cur_flags.address_match &&
                                  cur_flags.type_match;
          emit_verdict.sum_a_out = cur_a;
          emit_verdict.sum_b_out = cur_b;
        end
      end
    end
  end

  // result register update
  always_comb begin
    out_valid_d = out_valid_q;
    verdict_d = verdict_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      verdict_d = emit_verdict;
    end
  end

  // frame state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= '0;
      frame_len_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      addr_hi_q <= '0;
      flags_q <= '0;
      active_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      byte_pos_q <= byte_pos_d;
      frame_len_q <= frame_len_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      addr_hi_q <= addr_hi_d;
      flags_q <= flags_d;
      active_q <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // verdict payload
  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {{(rffc_pkg::OutDataW - $bits(rffc_pkg::verdict_t)){1'b0}},
                         verdict_q};

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseBytes  = 260;
  localparam int unsigned IdlePct     = 15;
  localparam int unsigned LongHold    = 400;

  // one row of the directed table: byte, start marker, optional fixed verdict
  typedef struct {
    logic [7:0]         rx_byte;
    logic               frame_start;
    bit                 fixed;
    rffc_pkg::verdict_t verdict;
  } byte_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [rffc_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [rffc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_we_i = 1'b0;
  logic [rffc_pkg::CfgIdxW-1:0]  cfg_addr_i = '0;
  logic [rffc_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  radio_frame_fletcher_checker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // rx_byte[7:0]
    .s_axis_tuser  (s_axis_tuser),   // frame_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // frame_ok, address_match, type_match, checksum_match,
                                     // length_error, sum_a_out, sum_b_out, zero padding
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow configuration
  logic [15:0] station_addr = rffc_pkg::StationAddressReset;
  logic [7:0]  wanted_type  = rffc_pkg::ExpectedFrameTypeReset;

  // shadow frame state
  logic [7:0]           frm_pos    = '0;
  logic [7:0]           frm_len    = '0;
  logic [7:0]           frm_sum_a  = '0;
  logic [7:0]           frm_sum_b  = '0;
  logic [7:0]           frm_addr_hi = '0;
  rffc_pkg::hdr_flags_t frm_flags  = '0;
  bit                   frm_active = 1'b0;

  rffc_pkg::verdict_t pending_verdicts [$];
  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned live_bytes = 0;
  int unsigned hold_left  = 0;
  bit          idle_en    = 1'b1;

  // directed stimulus, runs at the reset configuration
  byte_row_t directed_rows [24] = '{
    // short length with matching header: early rejection
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h06, 1'b0, 1'b1,
      rffc_pkg::verdict_t'{8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
    // stray byte while idle
    '{8'hff, 1'b0, 1'b0, '0},
    // shortest legal frame, good checksum: A = 9, B = 13
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h07, 1'b0, 1'b0, '0},
    '{8'h09, 1'b0, 1'b0, '0},
    '{8'h0d, 1'b0, 1'b1,
      rffc_pkg::verdict_t'{8'h0d, 8'h09, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}},
    // frame abandoned by a fresh start marker
    '{8'hff, 1'b1, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    // all-ones header bar the length byte, bad checksum bytes
    '{8'hff, 1'b1, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}
  };

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  // advance the shadow frame state by one byte; returns 1 when a verdict is due
  function automatic bit predict_frame_byte(input logic [7:0] rx_byte, input logic frame_start,
                                            output rffc_pkg::verdict_t verdict);
    logic [7:0] pos;
    verdict = '0;
    if (frame_start) begin
      frm_pos     = '0;
      frm_len     = '0;
      frm_sum_a   = '0;
      frm_sum_b   = '0;
      frm_addr_hi = '0;
      frm_flags   = '0;
      frm_active  = 1'b1;
    end
    if (!frm_active) return 1'b0;
    live_bytes++;
    pos     = frm_pos;
    frm_pos = frm_pos + 8'd1;

    // header bytes, covered by the sums unless the length is short
    if (pos <= rffc_pkg::LastHeaderPos) begin
      if (pos == rffc_pkg::PosAddrHigh) begin
        frm_addr_hi = rx_byte;
      end else if (pos == rffc_pkg::PosAddrLow) begin
        frm_flags.address_match = ({frm_addr_hi, rx_byte} == station_addr);
      end else if (pos == rffc_pkg::PosFrameType) begin
        frm_flags.type_match = (rx_byte == wanted_type);
      end else if (pos == rffc_pkg::PosLength) begin
        frm_len = rx_byte;
        if (rx_byte < rffc_pkg::MinFrameLength) begin
          verdict.length_error  = 1'b1;
          verdict.address_match = frm_flags.address_match;
          verdict.type_match    = frm_flags.type_match;
          frm_active = 1'b0;
          return 1'b1;
        end
      end
      frm_sum_a = frm_sum_a + rx_byte;
      frm_sum_b = frm_sum_b + frm_sum_a;
      return 1'b0;
    end

    // payload, then the two checksum bytes
    if ({1'b0, pos} + rffc_pkg::TrailerBytes < {1'b0, frm_len}) begin
      frm_sum_a = frm_sum_a + rx_byte;
      frm_sum_b = frm_sum_b + frm_sum_a;
      return 1'b0;
    end
    if ({1'b0, pos} + rffc_pkg::TrailerBytes == {1'b0, frm_len}) begin
      frm_flags.sum_a_match = (rx_byte == frm_sum_a);
      return 1'b0;
    end
    verdict.checksum_match = frm_flags.sum_a_match && (rx_byte == frm_sum_b);
    verdict.frame_ok       = verdict.checksum_match && frm_flags.address_match &&
                             frm_flags.type_match;
    verdict.address_match  = frm_flags.address_match;
    verdict.type_match     = frm_flags.type_match;
    verdict.sum_a_out      = frm_sum_a;
    verdict.sum_b_out      = frm_sum_b;
    frm_active = 1'b0;
    return 1'b1;
  endfunction

  // offer one byte, with an occasional random gap first, and predict once accepted
  task automatic send_byte(input logic [7:0] rx_byte, input logic frame_start,
                           input bit fixed, input rffc_pkg::verdict_t fixed_verdict);
    rffc_pkg::verdict_t verdict;
    bit                 due;
    if (idle_en && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx_byte;
    s_axis_tuser  <= frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
    due = predict_frame_byte(rx_byte, frame_start, verdict);
    if (fixed) pending_verdicts.push_back(fixed_verdict);
    else if (due) pending_verdicts.push_back(verdict);
  endtask

  // one frame, mostly well formed, sometimes short, corrupt, cut, or preceded or trailed by noise
  task automatic send_frame();
    logic [7:0] fbytes [$];
    logic [15:0] addr;
    logic [7:0] ftype;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    int flen;
    int pick;
    int cut;
    fbytes.delete();
    if ($urandom_range(0, 99) < 6)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    addr  = ($urandom_range(0, 3) != 0) ? station_addr : 16'($urandom_range(0, 65535));
    ftype = ($urandom_range(0, 3) != 0) ? wanted_type : 8'($urandom_range(0, 255));
    pick  = $urandom_range(0, 99);
    if (pick < 10)      flen = $urandom_range(0, 6);
    else if (pick < 12) flen = $urandom_range(100, 255);
    else                flen = $urandom_range(7, 16);
    fbytes = '{addr[15:8], addr[7:0], ftype, 8'($urandom_range(0, 255)), 8'(flen)};
    if (flen >= 7) begin
      while (fbytes.size() < flen - 2) fbytes.push_back(8'($urandom_range(0, 255)));
      sum_a = '0;
      sum_b = '0;
      foreach (fbytes[i]) begin
        sum_a = sum_a + fbytes[i];
        sum_b = sum_b + sum_a;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8)       sum_a = sum_a ^ 8'($urandom_range(1, 255));
      else if (pick < 16) sum_b = sum_b ^ 8'($urandom_range(1, 255));
      else if (pick < 20) begin
        sum_a = sum_a ^ 8'($urandom_range(1, 255));
        sum_b = sum_b ^ 8'($urandom_range(1, 255));
      end
      fbytes.push_back(sum_a);
      fbytes.push_back(sum_b);
    end
    cut = fbytes.size();
    if ($urandom_range(0, 99) < 5) cut = $urandom_range(1, fbytes.size() - 1);
    for (int i = 0; i < cut; i++) send_byte(fbytes[i], i == 0, 1'b0, '0);
    if ($urandom_range(0, 99) < 10)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
  endtask

  // wait for every verdict, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [rffc_pkg::CfgIdxW-1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      rffc_pkg::CfgStationAddress:    station_addr = value;
      rffc_pkg::CfgExpectedFrameType: wanted_type  = value[7:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // compare one accepted verdict with the oldest prediction
  task automatic check_verdict();
    rffc_pkg::verdict_t got;
    rffc_pkg::verdict_t want;
    got = rffc_pkg::verdict_t'(m_axis_tdata[$bits(rffc_pkg::verdict_t)-1:0]);
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("verdict %h with none pending", m_axis_tdata));
      return;
    end
    want = pending_verdicts.pop_front();
    check_field("frame_ok", int'(got.frame_ok), int'(want.frame_ok));
    check_field("address_match", int'(got.address_match), int'(want.address_match));
    check_field("type_match", int'(got.type_match), int'(want.type_match));
    check_field("checksum_match", int'(got.checksum_match), int'(want.checksum_match));
    check_field("length_error", int'(got.length_error), int'(want.length_error));
    check_field("sum_a_out", int'(got.sum_a_out), int'(want.sum_a_out));
    check_field("sum_b_out", int'(got.sum_b_out), int'(want.sum_b_out));
    check_field("padding",
                int'(m_axis_tdata[rffc_pkg::OutDataW-1:$bits(rffc_pkg::verdict_t)]), 0);
  endtask

  // verdict side: check, then choose the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_verdict();
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= !(idle_en && $urandom_range(0, 99) < IdlePct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [15:0] phase_addr [5];
    logic [7:0]  phase_type [5];
    int unsigned phase_end;
    phase_addr = '{16'h0000, 16'hffff, 16'($urandom_range(0, 65535)), 16'h8001,
                   16'($urandom_range(0, 65535))};
    phase_type = '{8'h00, 8'hff, 8'($urandom_range(0, 255)), 8'h02, 8'($urandom_range(0, 255))};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx_byte, directed_rows[i].frame_start,
                directed_rows[i].fixed, directed_rows[i].verdict);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(rffc_pkg::CfgStationAddress, phase_addr[ph]);
      write_cfg(rffc_pkg::CfgExpectedFrameType, {8'h00, phase_type[ph]});
      // a stretch with no idling on either side
      idle_en = (ph != 1);
      // receiver holds off long enough for the input to back up
      if (ph == 2) hold_left = LongHold;
      phase_end = live_bytes + PhaseBytes;
      while (live_bytes < phase_end) begin
        send_frame();
        // sender pauses once until everything has come out
        if (ph == 3 && live_bytes >= phase_end - PhaseBytes / 2 && live_bytes < phase_end) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending_verdicts.size() != 0) @(posedge clk_i);
          phase_end = live_bytes + PhaseBytes / 2;
          while (live_bytes < phase_end) send_frame();
        end
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rffc_pkg.sv
hdl/radio_frame_fletcher_checker_core.sv
verif/tb.sv
